@@ rtl/bpt_pkg.sv @@
// Shared types and constants of the beat period and phase tracker.
// Holds the controller state enum, command and status structs, widths.
// No dependencies.
package bpt_pkg;

  localparam int TIME_W        = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int DIV_W         = 48;  // serial divider dividend / quotient width
  localparam int DVS_W         = 33;  // serial divider divisor / remainder width
  localparam int HIST_DEPTH_DEF = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ACT_ON_RISING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC      = 2'd3;

  localparam logic [CFG_W-1:0]  RST_INITIAL_PERIOD = 16'd400;
  localparam logic [CFG_W-1:0]  RST_WINDOW_WIDTH   = 16'd10;
  localparam logic [39:0]       MIN_LIMIT_Q8       = 40'd256000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_PWALK,
    S_PDIV,
    S_QSET,
    S_QDIV,
    S_AWALK,
    S_ADIV,
    S_HSET,
    S_HDIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic push;
    logic pwalk_step;
    logic pdiv_start;
    logic pdiv_ld;
    logic qdiv_start;
    logic ainit;
    logic awalk_step;
    logic adiv_start;
    logic adiv_ld;
    logic hdiv_start;
    logic hdiv_ld;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pulse_now;
    logic period_zero;
    logic pwalk_stop;
    logic cnt_zero;
    logic x_neg;
    logic awalk_stop;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/bpt_div.sv @@
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on bpt_pkg for widths.
module bpt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bpt_pkg::DIV_W-1:0] dividend,
  input  logic [bpt_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [bpt_pkg::DIV_W-1:0] quot,
  output logic [bpt_pkg::DVS_W-1:0] rem
);
  import bpt_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] count;
  logic             busy;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem, quot[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quot <= {quot[DIV_W-2:0], fits};
    end
  end

endmodule

@@ rtl/bpt_ctrl.sv @@
// Sequencer of the tracker: walks one sample through edge, history,
// period, phase and hit steps. Depends on bpt_pkg.
module bpt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  bpt_pkg::sts_t sts,
  output bpt_pkg::cmd_t cmd,
  output logic          in_stall
);
  import bpt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = sts.pulse_now ? S_PUSH : S_HSET;
      S_PUSH:  state_next = sts.period_zero ? S_HSET : S_PWALK;
      S_PWALK: begin
        if (sts.pwalk_stop) state_next = sts.cnt_zero ? S_QSET : S_PDIV;
      end
      S_PDIV:  if (sts.div_done) state_next = S_QSET;
      S_QSET:  state_next = sts.x_neg ? S_AWALK : S_QDIV;
      S_QDIV:  if (sts.div_done) state_next = S_AWALK;
      S_AWALK: if (sts.awalk_stop) state_next = S_ADIV;
      S_ADIV:  if (sts.div_done) state_next = S_HSET;
      S_HSET:  state_next = sts.period_zero ? S_OUT : S_HDIV;
      S_HDIV:  if (sts.div_done) state_next = S_OUT;
      S_OUT:   if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.accept = in_valid;
      S_PUSH:  cmd.push = 1'b1;
      S_PWALK: begin
        cmd.pwalk_step = !sts.pwalk_stop;
        cmd.pdiv_start = sts.pwalk_stop && !sts.cnt_zero;
      end
      S_PDIV:  cmd.pdiv_ld = sts.div_done;
      S_QSET: begin
        cmd.ainit      = sts.x_neg;
        cmd.qdiv_start = !sts.x_neg;
      end
      S_QDIV:  cmd.ainit = sts.div_done;
      S_AWALK: begin
        cmd.awalk_step = !sts.awalk_stop;
        cmd.adiv_start = sts.awalk_stop;
      end
      S_ADIV:  cmd.adiv_ld = sts.div_done;
      S_HSET:  cmd.hdiv_start = !sts.period_zero;
      S_HDIV:  cmd.hdiv_ld = sts.div_done;
      S_OUT:   cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/bpt_dp.sv @@
// Datapath of the tracker: config registers, pulse history, walk
// accumulators, shared serial divider and output register. Uses bpt_pkg, bpt_div.
module bpt_dp #(
  parameter int HIST_DEPTH = bpt_pkg::HIST_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpt_pkg::CFG_W-1:0]     cfg_data,
  input  logic [bpt_pkg::TIME_W-1:0]    time_ms,
  input  logic                          level,
  input  logic                          out_stall,
  input  bpt_pkg::cmd_t                 cmd,
  output bpt_pkg::sts_t                 sts,
  output logic                          out_valid,
  output logic                          beat_hit,
  output logic [bpt_pkg::TIME_W-1:0]    period_q8,
  output logic [bpt_pkg::TIME_W-1:0]    align_ms,
  output logic                          pulse_taken
);
  import bpt_pkg::*;

  localparam int IDX_W = (HIST_DEPTH > 2) ? $clog2(HIST_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(HIST_DEPTH - 1);

  // configuration
  logic              act_on_rising;
  logic [CFG_W-1:0]  window_width;
  logic              symmetric;

  // tracker state
  logic [TIME_W-1:0] hist [HIST_DEPTH];
  logic [TIME_W-1:0] scan [HIST_DEPTH];
  logic              line_high;
  logic [TIME_W-1:0] rise_time;
  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] align;
  logic              align_set;
  logic              hit_latch;

  // per-sample work registers
  logic [TIME_W-1:0] t_s;
  logic [TIME_W-1:0] t0;
  logic              taken;
  logic              hit;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  cnt;
  logic [DIV_W-1:0]  sum;
  logic [39:0]       limit;
  logic [DIV_W-1:0]  qpa;
  logic [DIV_W-1:0]  tacc;

  // divider
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  logic [DVS_W-1:0]  div_rem;

  // combinational helpers
  logic              rise_now;
  logic              fall_now;
  logic              pulse_now;
  logic [TIME_W-1:0] pulse_time;
  logic [TIME_W-1:0] half_high;
  logic [TIME_W-1:0] gap;
  logic [39:0]       gap_q8;
  logic [34:0]       five_p;
  logic [TIME_W-1:0] align_new;
  logic [TIME_W-1:0] zero_diff;
  logic [41:0]       x_full;
  logic [40:0]       x_half;
  logic [TIME_W-1:0] lag;
  logic [TIME_W-1:0] hit_diff;

  assign rise_now   = level && !line_high;
  assign fall_now   = !level && line_high;
  assign pulse_now  = rise_now ? act_on_rising : (fall_now && !act_on_rising);
  assign half_high  = (time_ms - rise_time) >> 1;
  assign pulse_time = rise_now ? time_ms : rise_time + half_high;

  assign gap    = scan[0] - scan[1];
  assign gap_q8 = {gap, 8'b0};
  assign five_p = {period, 2'b0} + 35'(period);

  assign align_new = align_set ? align : t0;
  assign zero_diff = t0 - align_new;

  assign x_full = {1'b0, t0 - align, 9'b0} - 42'(period);
  assign x_half = (x_full[40:0] - 41'(div_rem)) >> 1;
  assign lag    = t0 - scan[0];
  assign hit_diff = t_s - align;

  always_comb begin
    sts.pulse_now   = pulse_now;
    sts.period_zero = (period == '0);
    sts.pwalk_stop  = (idx == LAST) || (gap_q8 >= limit);
    sts.cnt_zero    = (cnt == '0);
    sts.x_neg       = x_full[41];
    sts.awalk_stop  = (idx == LAST) ||
                      ((idx != '0) && (gap_q8 >= {7'b0, period, 1'b0}));
    sts.div_done    = div_done;
    sts.out_free    = !out_valid || !out_stall;
  end

  // pick the operands of whichever division starts now
  assign div_start = cmd.pdiv_start || cmd.qdiv_start || cmd.adiv_start || cmd.hdiv_start;

  always_comb begin
    priority if (cmd.pdiv_start) begin
      div_dividend = sum + DIV_W'(cnt);
      div_divisor  = DVS_W'({cnt, 1'b0});
    end else if (cmd.qdiv_start) begin
      div_dividend = DIV_W'(x_full[40:0]);
      div_divisor  = DVS_W'({period, 1'b0});
    end else if (cmd.adiv_start) begin
      div_dividend = ((tacc + DIV_W'(255)) >> 8) + DIV_W'(cnt) - DIV_W'(1);
      div_divisor  = DVS_W'(cnt);
    end else begin
      div_dividend = DIV_W'({hit_diff, 8'b0}) +
                     (symmetric ? DIV_W'({window_width, 7'b0}) : '0);
      div_divisor  = DVS_W'(period);
    end
  end

  bpt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // configuration, edge tracking and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      act_on_rising <= 1'b1;
      window_width  <= RST_WINDOW_WIDTH;
      symmetric     <= 1'b0;
      line_high     <= 1'b0;
      rise_time     <= '0;
      period        <= {16'b0, RST_INITIAL_PERIOD} << 8;
      align         <= '0;
      align_set     <= 1'b0;
      hit_latch     <= 1'b0;
      for (int k = 0; k < HIST_DEPTH; k++) hist[k] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ACT_ON_RISING:  act_on_rising <= cfg_data[0];
          CFG_INITIAL_PERIOD: period <= {16'b0, cfg_data} << 8;
          CFG_WINDOW_WIDTH:   window_width <= cfg_data;
          CFG_SYMMETRIC:      symmetric <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (rise_now) begin
          line_high <= 1'b1;
          rise_time <= time_ms;
        end else if (fall_now) begin
          line_high <= 1'b0;
        end
      end
      if (cmd.push) begin
        for (int k = HIST_DEPTH - 1; k > 0; k--) hist[k] <= hist[k-1];
        hist[0] <= t0;
        if (period == '0) begin
          align     <= align_new;
          align_set <= 1'b1;
          period    <= (zero_diff[31:24] != '0) ? '1 : {zero_diff[23:0], 8'b0};
        end
      end
      if (cmd.pdiv_ld) begin
        period <= (div_quot[DIV_W-1:TIME_W] != '0) ? '1 : div_quot[TIME_W-1:0];
      end
      if (cmd.adiv_ld) begin
        align     <= t0 - div_quot[TIME_W-1:0];
        align_set <= 1'b1;
      end
      if (cmd.hdiv_ld) begin
        if (div_rem < DVS_W'({window_width, 8'b0})) begin
          hit_latch <= 1'b1;
        end else begin
          hit_latch <= 1'b0;
        end
      end
    end
  end

  // walk registers and per-sample payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_s   <= time_ms;
      t0    <= pulse_time;
      taken <= pulse_now;
      hit   <= 1'b0;
    end
    if (cmd.push) begin
      scan[0] <= t0;
      for (int k = 1; k < HIST_DEPTH; k++) scan[k] <= hist[k-1];
      idx   <= '0;
      cnt   <= '0;
      sum   <= '0;
      limit <= (40'(five_p) < MIN_LIMIT_Q8) ? MIN_LIMIT_Q8 : 40'(five_p);
    end
    if (cmd.pwalk_step || cmd.awalk_step) begin
      for (int k = 0; k < HIST_DEPTH - 1; k++) scan[k] <= scan[k+1];
      scan[HIST_DEPTH-1] <= '0;
      idx <= idx + 1'b1;
      cnt <= cnt + 1'b1;
    end
    if (cmd.pwalk_step) begin
      sum <= sum + DIV_W'(gap_q8) + DIV_W'(period);
    end
    if (cmd.ainit) begin
      for (int k = 0; k < HIST_DEPTH; k++) scan[k] <= hist[k];
      idx  <= '0;
      cnt  <= '0;
      tacc <= '0;
      qpa  <= x_full[41] ? DIV_W'(period)
                         : DIV_W'(x_half) + DIV_W'({period, 1'b0});
    end
    if (cmd.awalk_step) begin
      tacc <= tacc + DIV_W'({lag, 8'b0}) + qpa;
      qpa  <= qpa + DIV_W'(period);
    end
    if (cmd.hdiv_ld) begin
      hit <= (div_rem < DVS_W'({window_width, 8'b0})) && !hit_latch;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      beat_hit    <= hit;
      period_q8   <= period;
      align_ms    <= align;
      pulse_taken <= taken;
    end
  end

endmodule

@@ rtl/beat_period_phase_tracker_top.sv @@
// Top level of the beat period and phase tracker.
// Instantiates bpt_ctrl and bpt_dp; uses bpt_pkg.
//
//   channel  direction  handshake              word
//   in       into block in_valid / in_stall    time_ms, level
//   out      from block out_valid / out_stall  beat_hit, period_q8, align_ms, pulse_taken
//   cfg      into block cfg_we                 cfg_index, cfg_data
//
// A sample without a pulse needs at most one division, by the period, in the
// shared bit-serial divider; there is none while the period is zero.
// A sample with a pulse adds up to two history walks and up to three more
// divisions, and the sequencer holds in its output state while the output
// word is stalled.
// Synchronous active-high reset clears the history, edge state, latch and
// loads the default registers. One sample is worked at a time; in_stall is
// high from acceptance until the result is handed to the output register,
// which holds a word while out_stall is high, and the next sample is taken
// while it waits.
module beat_period_phase_tracker_top #(
  parameter int HIST_DEPTH = bpt_pkg::HIST_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpt_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bpt_pkg::TIME_W-1:0]    time_ms,
  input  logic                          level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          beat_hit,
  output logic [bpt_pkg::TIME_W-1:0]    period_q8,
  output logic [bpt_pkg::TIME_W-1:0]    align_ms,
  output logic                          pulse_taken
);
  import bpt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one state per step of the sample's work
  bpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // history, period and phase arithmetic, hit window, output word
  bpt_dp #(
    .HIST_DEPTH (HIST_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .time_ms     (time_ms),
    .level       (level),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .beat_hit    (beat_hit),
    .period_q8   (period_q8),
    .align_ms    (align_ms),
    .pulse_taken (pulse_taken)
  );

endmodule

@@ tb/sv/bpt_checker.sv @@
// Checker of the beat period and phase tracker: watches the cfg, in and out ports,
// predicts each result word and compares it with the word on the out port. Depends on bpt_pkg.
`timescale 1ns / 100ps
module bpt_checker
  import bpt_pkg::*;
#(
  parameter int HD = HIST_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [TIME_W-1:0]    time_ms,
  input  logic                 level,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 beat_hit,
  input  logic [TIME_W-1:0]    period_q8,
  input  logic [TIME_W-1:0]    align_ms,
  input  logic                 pulse_taken,
  output int                   fails,
  output int                   pending
);

  typedef struct packed {
    logic        hit;
    logic [31:0] per;
    logic [31:0] align;
    logic        taken;
  } beat_word_t;

  beat_word_t word_q[$];

  logic        r_rising, r_sym;
  logic [15:0] r_width;
  logic [31:0] pulse_hist [HD];
  logic        line_hi, latch, align_valid;
  logic [31:0] rise_t, per_est, align_ref;

  function automatic logic [31:0] sat32(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic longint unsigned gap_q8(logic [31:0] newer, logic [31:0] older);
    logic [31:0] d;
    d = newer - older;
    return longint'(d) << 8;
  endfunction

  // Push a pulse time, re-estimate period and phase.
  task automatic log_pulse(input logic [31:0] t);
    longint unsigned p, lim, sum, cnt, g, d0;
    longint x, q, s, n, mean;
    logic [31:0] dt;
    for (int i = HD - 1; i > 0; i--) pulse_hist[i] = pulse_hist[i-1];
    pulse_hist[0] = t;
    if (per_est == 0) begin
      if (!align_valid) begin
        align_ref = t;
        align_valid = 1'b1;
      end
      per_est = sat32(gap_q8(t, align_ref));
      return;
    end
    p = per_est;
    lim = 5 * p;
    if (lim < 256000) lim = 256000;
    sum = 0;
    cnt = 0;
    for (int i = 0; i < HD - 1; i++) begin
      g = gap_q8(pulse_hist[i], pulse_hist[i+1]);
      if (g >= lim) break;
      sum += g + p;
      cnt++;
    end
    if (cnt != 0) per_est = sat32((sum + cnt) / (2 * cnt));
    p = per_est;
    dt = pulse_hist[0] - align_ref;
    d0 = longint'(dt);
    x = longint'(d0 << 9) - longint'(p);
    q = (x < 0) ? 0 : x / longint'(2 * p) + 1;
    s = 0;
    n = 0;
    for (int i = 0; i < HD - 1; i++) begin
      if (i > 0 && gap_q8(pulse_hist[i], pulse_hist[i+1]) >= 2 * p) break;
      s -= longint'(gap_q8(pulse_hist[0], pulse_hist[i]));
      s -= (q + i + 1) * longint'(p);
      n++;
    end
    if (s >= 0) mean = s / (256 * n);
    else mean = -((-s + 256 * n - 1) / (256 * n));
    align_ref = pulse_hist[0] + mean[31:0];
    align_valid = 1'b1;
  endtask

  task automatic predict_word(input logic [31:0] t, input logic lv, output beat_word_t w);
    longint unsigned xq;
    logic [31:0] dt;
    w = '0;
    if (lv) begin
      if (!line_hi) begin
        rise_t = t;
        line_hi = 1'b1;
        if (r_rising) begin
          log_pulse(t);
          w.taken = 1'b1;
        end
      end
    end else if (line_hi) begin
      line_hi = 1'b0;
      if (!r_rising) begin
        dt = t - rise_t;
        log_pulse(rise_t + (dt >> 1));
        w.taken = 1'b1;
      end
    end
    if (per_est != 0) begin
      dt = t - align_ref;
      xq = longint'(dt) << 8;
      if (r_sym) xq += longint'(r_width) << 7;
      if ((xq % per_est) < (longint'(r_width) << 8)) begin
        w.hit = !latch;
        latch = 1'b1;
      end else begin
        latch = 1'b0;
      end
    end
    w.per = per_est;
    w.align = align_ref;
  endtask

  assign pending = word_q.size();

  always @(posedge clk) begin
    beat_word_t exp_w, got_w;
    if (rst) begin
      r_rising = 1'b1;
      r_width = RST_WINDOW_WIDTH;
      r_sym = 1'b0;
      for (int i = 0; i < HD; i++) pulse_hist[i] = '0;
      line_hi = 1'b0;
      latch = 1'b0;
      align_valid = 1'b0;
      rise_t = '0;
      align_ref = '0;
      per_est = {8'd0, RST_INITIAL_PERIOD, 8'd0};
      word_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACT_ON_RISING: r_rising = cfg_data[0];
          CFG_INITIAL_PERIOD: per_est = {8'd0, cfg_data, 8'd0};
          CFG_WINDOW_WIDTH: r_width = cfg_data;
          CFG_SYMMETRIC: r_sym = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_word(time_ms, level, exp_w);
        word_q = {word_q, exp_w};
      end
      if (out_valid && !out_stall) begin
        got_w = '{beat_hit, period_q8, align_ms, pulse_taken};
        if (word_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected out word: %p", got_w);
        end else begin
          exp_w = word_q.pop_front();
          if (got_w !== exp_w) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp hit=%0b per=%h align=%h taken=%0b, got hit=%0b per=%h align=%h taken=%0b",
                       exp_w.hit, exp_w.per, exp_w.align, exp_w.taken,
                       got_w.hit, got_w.per, got_w.align, got_w.taken);
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_beat_period_phase_tracker_top.sv @@
// Testbench top of the beat period and phase tracker: clock, reset, stimulus, verdict.
// Depends on bpt_pkg, beat_period_phase_tracker_top and bpt_checker.
`timescale 1ns / 100ps
module tb_beat_period_phase_tracker_top;
  import bpt_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int DRAIN_CYCLES = 300;  // idle wait after the last word has left

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ACT_ON_RISING;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_W-1:0]    time_ms = '0;
  logic                 level = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 beat_hit;
  logic [TIME_W-1:0]    period_q8;
  logic [TIME_W-1:0]    align_ms;
  logic                 pulse_taken;

  int          fails, pending;
  int          cycles = 0;
  int          sent = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;  // no idling on either side in the final phase
  logic [31:0] now_ms;

  beat_period_phase_tracker_top dut (.*);

  bpt_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, pending);
      $display("[beat_period_phase_tracker_top] ERROR");
      $finish;
    end
  end

  // Hold off the out channel in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one sample word; keep valid high across back-to-back words,
  // drop it only for an idle burst.
  task automatic send_sample(input logic [31:0] t, input logic lv);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    time_ms <= t;
    level <= lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Write all four registers on consecutive edges; the block must be idle.
  task automatic load_regs(input logic rising, input logic [15:0] init_ms,
                           input logic [15:0] width_ms, input logic sym);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ACT_ON_RISING;
    cfg_data <= {15'd0, rising};
    @(posedge clk);
    cfg_index <= CFG_INITIAL_PERIOD;
    cfg_data <= init_ms;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_WIDTH;
    cfg_data <= width_ms;
    @(posedge clk);
    cfg_index <= CFG_SYMMETRIC;
    cfg_data <= {15'd0, sym};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sample a square beat line every ~20 ms; mostly clean, with some noise:
  // time jumps, level glitches and fully random words.
  task automatic beat_train(input int n, input int per_ms, input int hi_ms, input int jit);
    logic [31:0] origin, dt;
    logic        lv;
    int          pick;
    origin = now_ms;
    for (int k = 0; k < n; k++) begin
      now_ms += 20 + $urandom_range(0, jit);
      dt = now_ms - origin;
      lv = (dt % per_ms) < hi_ms;
      pick = $urandom_range(0, 31);
      if (pick == 0) begin
        now_ms += $urandom_range(500, 5000);  // dropout, a long gap
      end else if (pick == 1) begin
        lv = !lv;                             // glitch
      end else if (pick == 2) begin
        send_sample($urandom, $urandom_range(0, 1));
        continue;
      end
      send_sample(now_ms, lv);
    end
  endtask

  initial begin
    now_ms = 32'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: time extremes, both levels, edges back to back.
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h0000_0014, 1'b1);
    send_sample(32'h0000_0028, 1'b0);
    send_sample(32'h0000_0190, 1'b1);
    send_sample(32'h0000_01A4, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_0013, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'hAAAA_AAAA, 1'b1);
    send_sample(32'h5555_5555, 1'b0);

    // Zero period: the first pulse sets the period from the phase already held.
    load_regs(1'b1, 16'd0, 16'd20, 1'b0);
    send_sample(32'd1000, 1'b1);
    send_sample(32'd1020, 1'b0);
    send_sample(32'd1500, 1'b1);
    send_sample(32'd1520, 1'b0);
    send_sample(32'd2000, 1'b1);
    now_ms = 32'd2000;
    beat_train(60, 500, 80, 3);

    // Midpoint pulses, centred window, wrap of the time counter.
    load_regs(1'b0, 16'd450, 16'd30, 1'b1);
    now_ms = 32'hFFFF_E000;
    beat_train(120, 450, 100, 4);

    // Extremes: huge period and window, then zero window.
    load_regs(1'b1, 16'd65535, 16'd65535, 1'b1);
    beat_train(60, 600, 60, 2);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    load_regs(1'b0, 16'd1, 16'd0, 1'b0);
    beat_train(60, 300, 120, 5);

    // Random settings, random beat rates.
    for (int ph = 0; ph < 4; ph++) begin
      load_regs($urandom_range(0, 1), $urandom_range(200, 900),
                $urandom_range(1, 60), $urandom_range(0, 1));
      beat_train(70, $urandom_range(250, 900), $urandom_range(30, 200), $urandom_range(0, 8));
    end

    // Last stretch runs at full rate with no idling on either side.
    load_regs(1'b1, 16'd500, 16'd15, 1'b0);
    quiet = 1'b1;
    beat_train(80, 520, 90, 2);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d sample words over nine register settings, zero and extreme", sent);
    $display("periods and windows, both pulse modes, time wrap, noise; %0d mismatches", fails);
    if (fails == 0) begin
      $display("[beat_period_phase_tracker_top] OK");
    end else begin
      $display("[beat_period_phase_tracker_top] ERROR");
    end
    $finish;
  end

endmodule
